FILE: src/bli_pkg.sv
// shared constants, codes and controller/datapath interface types for the interpolator
package bli_pkg;

  localparam int MAX_POINTS = 64;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int DIV_STEPS  = 32;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
  localparam int CFG_IDX_W  = 1;

  localparam logic [1:0] OP_CLEAR     = 2'd0;
  localparam logic [1:0] OP_APPEND    = 2'd1;
  localparam int         OP_QUERY_BIT = 1;

  localparam logic [2:0] ST_INTERP  = 3'd0;
  localparam logic [2:0] ST_LOW     = 3'd1;
  localparam logic [2:0] ST_HIGH    = 3'd2;
  localparam logic [2:0] ST_DEFAULT = 3'd3;
  localparam logic [2:0] ST_STORED  = 3'd4;
  localparam logic [2:0] ST_FULL    = 3'd5;
  localparam logic [2:0] ST_CLEARED = 3'd6;

  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_ENABLED = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_VALUE = 1'b1;

  typedef enum logic [1:0] {
    RD_ZERO,
    RD_LAST,
    RD_NEXT
  } rd_sel_t;

  typedef enum logic [2:0] {
    RES_DEFAULT,
    RES_FIRST,
    RES_LAST_RD,
    RES_LAST_REG,
    RES_INTERP,
    RES_STORED,
    RES_FULL,
    RES_CLEARED
  } res_sel_t;

  typedef struct packed {
    logic     load_in;
    logic     write_entry;
    logic     clear_count;
    logic     rd_en;
    rd_sel_t  rd_sel;
    logic     idx_step;
    logic     cap_prev;
    logic     cap_last;
    logic     cap_seg;
    logic     calc_diff;
    logic     mul_start;
    logic     div_step;
    logic     res_load;
    res_sel_t res_sel;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       tbl_ok;
    logic       full;
    logic       le_first;
    logic       ge_last;
    logic       seg_hit;
    logic       scan_end;
    logic       div_last;
    logic       out_free;
  } dp_sts_t;

endpackage

FILE: src/bli_ctrl.sv
// sequencing state machine for clear, append and query beats
module bli_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  bli_pkg::dp_sts_t sts,
  output bli_pkg::dp_cmd_t cmd
);
  import bli_pkg::*;

  typedef enum logic [3:0] {
    IDLE,
    DECODE,
    Q_FIRST,
    Q_LAST,
    Q_SCAN,
    Q_DIFF,
    Q_MUL,
    Q_DIV,
    Q_ADD,
    FINISH
  } state_t;

  state_t state;
  state_t state_next;

  assign s_axis_tready = (state == IDLE);

  always_comb begin
    cmd        = '0;
    cmd.rd_sel  = RD_ZERO;
    cmd.res_sel = RES_DEFAULT;
    state_next = state;
    case (state)
      IDLE: begin
        if (s_axis_tvalid) begin
          cmd.load_in = 1'b1;
          state_next  = DECODE;
        end
      end
      DECODE: begin
        if (sts.op[OP_QUERY_BIT]) begin
          if (!sts.tbl_ok) begin
            cmd.res_load = 1'b1;
            cmd.res_sel  = RES_DEFAULT;
            state_next   = FINISH;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_ZERO;
            state_next = Q_FIRST;
          end
        end else if (sts.op == OP_APPEND) begin
          cmd.res_load = 1'b1;
          if (sts.full) begin
            cmd.res_sel = RES_FULL;
          end else begin
            cmd.write_entry = 1'b1;
            cmd.res_sel     = RES_STORED;
          end
          state_next = FINISH;
        end else begin
          cmd.clear_count = 1'b1;
          cmd.res_load    = 1'b1;
          cmd.res_sel     = RES_CLEARED;
          state_next      = FINISH;
        end
      end
      Q_FIRST: begin
        if (sts.le_first) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = RES_FIRST;
          state_next   = FINISH;
        end else begin
          cmd.cap_prev = 1'b1;
          cmd.rd_en    = 1'b1;
          cmd.rd_sel   = RD_LAST;
          state_next   = Q_LAST;
        end
      end
      Q_LAST: begin
        if (sts.ge_last) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = RES_LAST_RD;
          state_next   = FINISH;
        end else begin
          cmd.cap_last = 1'b1;
          cmd.rd_en    = 1'b1;
          cmd.rd_sel   = RD_NEXT;
          cmd.idx_step = 1'b1;
          state_next   = Q_SCAN;
        end
      end
      Q_SCAN: begin
        if (sts.seg_hit) begin
          cmd.cap_seg = 1'b1;
          state_next  = Q_DIFF;
        end else if (sts.scan_end) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = RES_LAST_REG;
          state_next   = FINISH;
        end else begin
          cmd.cap_prev = 1'b1;
          cmd.rd_en    = 1'b1;
          cmd.rd_sel   = RD_NEXT;
          cmd.idx_step = 1'b1;
        end
      end
      Q_DIFF: begin
        cmd.calc_diff = 1'b1;
        state_next    = Q_MUL;
      end
      Q_MUL: begin
        cmd.mul_start = 1'b1;
        state_next    = Q_DIV;
      end
      Q_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = Q_ADD;
        end
      end
      Q_ADD: begin
        cmd.res_load = 1'b1;
        cmd.res_sel  = RES_INTERP;
        state_next   = FINISH;
      end
      FINISH: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: src/bli_dp.sv
// datapath: breakpoint memory, scan registers, serial divider and output register
module bli_dp (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [63:0]                    s_axis_tdata,
  input  logic [1:0]                     s_axis_tuser,
  output logic [31:0]                    m_axis_tdata,
  output logic [2:0]                     m_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic                           cfg_we,
  input  logic [bli_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                    cfg_data,
  input  bli_pkg::dp_cmd_t               cmd,
  output bli_pkg::dp_sts_t               sts
);
  import bli_pkg::*;

  logic              table_enabled;
  logic [31:0]       default_value;
  logic [1:0]        in_op;
  logic [31:0]       in_t;
  logic [31:0]       in_v;
  logic [CNT_W-1:0]  count;
  logic [IDX_W-1:0]  idx;
  logic [IDX_W-1:0]  rd_addr;
  logic [IDX_W-1:0]  last_idx;
  logic [63:0]       mem [MAX_POINTS];
  logic [63:0]       rd_data;
  logic [31:0]       rd_t;
  logic [31:0]       rd_v;
  logic [31:0]       prev_t;
  logic [31:0]       prev_v;
  logic [31:0]       last_v;
  logic [31:0]       seg_a;
  logic [31:0]       seg_b;
  logic [31:0]       dt;
  logic [31:0]       span;
  logic              neg;
  logic [31:0]       mag;
  logic [32:0]       dv;
  logic [32:0]       dv_neg;
  logic [63:0]       prod;
  logic [31:0]       rem;
  logic [31:0]       quo;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [32:0]       trial;
  logic [32:0]       trial_sub;
  logic              trial_ge;
  logic [31:0]       interp;
  logic [31:0]       res_value;
  logic [2:0]        res_status;
  logic [31:0]       res_value_next;
  logic [2:0]        res_status_next;

  assign rd_t     = rd_data[31:0];
  assign rd_v     = rd_data[63:32];
  assign last_idx = IDX_W'(count - CNT_W'(1));

  always_comb begin
    case (cmd.rd_sel)
      RD_ZERO: rd_addr = '0;
      RD_LAST: rd_addr = last_idx;
      RD_NEXT: rd_addr = idx + IDX_W'(1);
      default: rd_addr = '0;
    endcase
  end

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      table_enabled <= 1'b1;
      default_value <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TABLE_ENABLED: table_enabled <= cfg_data[0];
        CFG_DEFAULT_VALUE: default_value <= cfg_data;
        default: ;
      endcase
    end
  end

  // breakpoint memory, value in the upper half
  always_ff @(posedge clk) begin
    if (cmd.write_entry) begin
      mem[count[IDX_W-1:0]] <= {in_v, in_t};
    end
    if (cmd.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.clear_count) begin
      count <= '0;
    end else if (cmd.write_entry) begin
      count <= count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_op <= s_axis_tuser;
      in_t  <= s_axis_tdata[31:0];
      in_v  <= s_axis_tdata[63:32];
      idx   <= '0;
    end else if (cmd.idx_step) begin
      idx <= idx + IDX_W'(1);
    end
    if (cmd.cap_prev) begin
      prev_t <= rd_t;
      prev_v <= rd_v;
    end
    if (cmd.cap_last) begin
      last_v <= rd_v;
    end
    if (cmd.cap_seg) begin
      seg_a <= prev_v;
      seg_b <= rd_v;
      dt    <= in_t - prev_t;
      span  <= rd_t - prev_t;
    end
  end

  // signed difference and its magnitude
  assign dv     = {seg_b[31], seg_b} - {seg_a[31], seg_a};
  assign dv_neg = ~dv + 33'd1;

  always_ff @(posedge clk) begin
    if (cmd.calc_diff) begin
      neg <= dv[32];
      mag <= dv[32] ? dv_neg[31:0] : dv[31:0];
    end
  end

  // restoring divider, one quotient bit per cycle
  assign prod      = {32'd0, mag} * {32'd0, dt};
  assign trial     = {rem, quo[31]};
  assign trial_ge  = (trial >= {1'b0, span});
  assign trial_sub = trial - {1'b0, span};

  always_ff @(posedge clk) begin
    if (cmd.mul_start) begin
      rem     <= prod[63:32];
      quo     <= prod[31:0];
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      rem     <= trial_ge ? trial_sub[31:0] : trial[31:0];
      quo     <= {quo[30:0], trial_ge};
      div_cnt <= div_cnt + DIV_CNT_W'(1);
    end
  end

  assign interp = neg ? (seg_a - quo) : (seg_a + quo);

  always_comb begin
    case (cmd.res_sel)
      RES_DEFAULT: begin
        res_value_next  = default_value;
        res_status_next = ST_DEFAULT;
      end
      RES_FIRST: begin
        res_value_next  = rd_v;
        res_status_next = ST_LOW;
      end
      RES_LAST_RD: begin
        res_value_next  = rd_v;
        res_status_next = ST_HIGH;
      end
      RES_LAST_REG: begin
        res_value_next  = last_v;
        res_status_next = ST_HIGH;
      end
      RES_INTERP: begin
        res_value_next  = interp;
        res_status_next = ST_INTERP;
      end
      RES_STORED: begin
        res_value_next  = '0;
        res_status_next = ST_STORED;
      end
      RES_FULL: begin
        res_value_next  = '0;
        res_status_next = ST_FULL;
      end
      RES_CLEARED: begin
        res_value_next  = '0;
        res_status_next = ST_CLEARED;
      end
      default: begin
        res_value_next  = '0;
        res_status_next = ST_CLEARED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_value  <= res_value_next;
      res_status <= res_status_next;
    end
    if (cmd.out_load) begin
      m_axis_tdata <= res_value;
      m_axis_tuser <= res_status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_comb begin
    sts.op       = in_op;
    sts.tbl_ok   = table_enabled && (count != '0);
    sts.full     = (count == CNT_W'(MAX_POINTS));
    sts.le_first = (in_t <= rd_t);
    sts.ge_last  = (in_t >= rd_t);
    sts.seg_hit  = (in_t >= prev_t) && (in_t < rd_t);
    sts.scan_end = (CNT_W'(idx) == (count - CNT_W'(1)));
    sts.div_last = (div_cnt == DIV_CNT_W'(DIV_STEPS - 1));
    sts.out_free = !m_axis_tvalid || m_axis_tready;
  end

endmodule

FILE: src/breakpoint_linear_interpolator_top.sv
// top level of the breakpoint table linear interpolator
//
//   channel   dir  handshake              payload
//   s_axis    in   tvalid/tready          tdata: sample_time, sample_value; tuser: op
//   m_axis    out  tvalid/tready          tdata: result_value; tuser: status
//   cfg       in   cfg_we                 cfg_index, cfg_data
//
// clear and append go from accept through DECODE and FINISH to the output register
// a query scans the breakpoint memory one entry per cycle over its single read port,
// then runs a serial restoring divider and adds the quotient to the segment start value
// one beat is in flight at a time; s_axis_tready is high only while idle
// a finished beat waits in the output register while m_axis_tready is low
// rst is synchronous; it empties the table and restores the config reset values
module breakpoint_linear_interpolator_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [63:0]                   s_axis_tdata,  // [31:0] sample_time, [63:32] sample_value
  input  logic [1:0]                    s_axis_tuser,  // [1:0] op
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [31:0]                   m_axis_tdata,  // [31:0] result_value
  output logic [2:0]                    m_axis_tuser,  // [2:0] status
  input  logic                          cfg_we,
  input  logic [bli_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data
);
  import bli_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  bli_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .sts           (sts),
    .cmd           (cmd)
  );

  bli_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cmd           (cmd),
    .sts           (sts)
  );

endmodule

FILE: test/bli_result_checker.sv
// result checker for the breakpoint interpolator: predicts each beat and compares the results
module bli_result_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  input  logic [63:0]                   s_axis_tdata,
  input  logic [1:0]                    s_axis_tuser,
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic [31:0]                   m_axis_tdata,
  input  logic [2:0]                    m_axis_tuser,
  input  logic                          cfg_we,
  input  logic [bli_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data,
  output int                            mismatch_count,
  output int                            pending_results
);
  timeunit 1ns;
  timeprecision 1ps;

  import bli_pkg::*;

  typedef struct packed {
    logic [31:0] value;
    logic [2:0]  status;
  } lookup_result_t;

  logic [31:0]    bp_time  [MAX_POINTS];
  logic [31:0]    bp_value [MAX_POINTS];
  int unsigned    bp_count;
  logic           tbl_enabled;
  logic [31:0]    dflt_value;
  lookup_result_t expected_results [$];

  initial begin
    mismatch_count  = 0;
    pending_results = 0;
    bp_count        = 0;
    tbl_enabled     = 1'b1;
    dflt_value      = '0;
  end

  // v0 + trunc(dt * (v1 - v0) / span), all in 64-bit two's complement
  function automatic logic [31:0] segment_value(logic [31:0] v0, logic [31:0] v1,
                                                logic [31:0] dt, logic [31:0] span);
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] dv;
    logic [63:0] mag;
    logic [63:0] quo;
    logic [63:0] sum;
    a   = {{32{v0[31]}}, v0};
    b   = {{32{v1[31]}}, v1};
    dv  = b - a;
    mag = dv[63] ? -dv : dv;
    quo = (mag * {32'd0, dt}) / {32'd0, span};
    sum = dv[63] ? a - quo : a + quo;
    return sum[31:0];
  endfunction

  function automatic lookup_result_t lookup_time(logic [31:0] t);
    lookup_result_t res;
    int unsigned    last;
    if (!tbl_enabled || bp_count == 0) begin
      res.value  = dflt_value;
      res.status = ST_DEFAULT;
      return res;
    end
    last = bp_count - 1;
    if (t <= bp_time[0]) begin
      res.value  = bp_value[0];
      res.status = ST_LOW;
      return res;
    end
    if (t >= bp_time[last]) begin
      res.value  = bp_value[last];
      res.status = ST_HIGH;
      return res;
    end
    for (int unsigned i = 0; i < last; i++) begin
      if (t >= bp_time[i] && t < bp_time[i+1]) begin
        res.value  = segment_value(bp_value[i], bp_value[i+1], t - bp_time[i],
                                   bp_time[i+1] - bp_time[i]);
        res.status = ST_INTERP;
        return res;
      end
    end
    res.value  = bp_value[last];
    res.status = ST_HIGH;
    return res;
  endfunction

  function automatic lookup_result_t apply_beat(logic [1:0] op, logic [31:0] t,
                                                logic [31:0] v);
    lookup_result_t res;
    res.value = '0;
    if (op[OP_QUERY_BIT]) begin
      res = lookup_time(t);
    end else if (op == OP_APPEND) begin
      if (bp_count < MAX_POINTS) begin
        bp_time[bp_count]  = t;
        bp_value[bp_count] = v;
        bp_count++;
        res.status = ST_STORED;
      end else begin
        res.status = ST_FULL;
      end
    end else begin
      bp_count   = 0;
      res.status = ST_CLEARED;
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: %s: got %h, expected %h", $time, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    lookup_result_t want;
    if (rst) begin
      bp_count    = 0;
      tbl_enabled = 1'b1;
      dflt_value  = '0;
      expected_results.delete();
    end else begin
      if (m_axis_tvalid === 1'b1 && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result beat with nothing pending", m_axis_tdata, '0);
        end else begin
          want = expected_results.pop_front();
          if (m_axis_tdata !== want.value)
            report_mismatch("result_value", m_axis_tdata, want.value);
          if (m_axis_tuser !== want.status)
            report_mismatch("status", 32'(m_axis_tuser), 32'(want.status));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_TABLE_ENABLED: tbl_enabled = cfg_data[0];
          CFG_DEFAULT_VALUE: dflt_value  = cfg_data;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready === 1'b1)
        expected_results.insert(expected_results.size(),
                                apply_beat(s_axis_tuser, s_axis_tdata[31:0],
                                           s_axis_tdata[63:32]));
    end
    pending_results = expected_results.size();
  end

endmodule

FILE: test/tb_breakpoint_linear_interpolator_top.sv
// testbench top for the breakpoint interpolator: stimulus, flow control and verdict
module tb_breakpoint_linear_interpolator_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bli_pkg::*;

  localparam logic [1:0]  OP_QUERY     = 2'd2;
  localparam logic [1:0]  OP_QUERY_ALT = 2'd3;
  localparam int          RANDOM_BEATS = 450;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          DRAIN_CYCLES = 150;

  logic                 clk           = 1'b0;
  logic                 rst           = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [63:0]          s_axis_tdata  = '0;
  logic [1:0]           s_axis_tuser  = OP_CLEAR;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [31:0]          m_axis_tdata;
  logic [2:0]           m_axis_tuser;
  logic                 cfg_we        = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index     = CFG_TABLE_ENABLED;
  logic [31:0]          cfg_data      = '0;

  int          mismatch_count;
  int          pending_results;
  int unsigned cycle_count = 0;
  int unsigned beats_sent  = 0;
  bit          idle_on     = 1'b0;
  bit          hold_req    = 1'b0;
  int unsigned hold_left   = 0;
  int unsigned stall_left  = 0;
  logic [31:0] table_times [$];

  breakpoint_linear_interpolator_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  bli_result_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .s_axis_tuser    (s_axis_tuser),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .m_axis_tuser    (m_axis_tuser),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatch_count  (mismatch_count),
    .pending_results (pending_results)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_breakpoint_linear_interpolator_top: FAIL");
      $finish;
    end
  end

  // mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!idle_on)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    if (r < 90)
      return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // result side flow control, with a long hold-off on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready = 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      m_axis_tready = 1'b0;
    end else if (idle_on && $urandom_range(0, 3) == 0) begin
      stall_left    = pick_gap();
      m_axis_tready = 1'b0;
    end else begin
      m_axis_tready = 1'b1;
    end
  end

  task automatic send_beat(input logic [1:0] op, input logic [31:0] t, input logic [31:0] v);
    int unsigned gap;
    gap = pick_gap();
    repeat (gap) @(negedge clk);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {v, t};
    s_axis_tuser  = op;
    do @(posedge clk); while (s_axis_tready !== 1'b1);
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    beats_sent++;
    if (op[OP_QUERY_BIT]) begin
    end else if (op == OP_APPEND) begin
      if (table_times.size() < MAX_POINTS)
        table_times.insert(table_times.size(), t);
    end else begin
      table_times.delete();
    end
  endtask

  task automatic wait_idle();
    while (pending_results != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    wait_idle();
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return $urandom_range(0, 200) - 100;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_query_time();
    int unsigned n;
    int unsigned i;
    logic [31:0] lo;
    logic [31:0] hi;
    n = table_times.size();
    if (n == 0)
      return $urandom;
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return table_times[$urandom_range(0, n - 1)];
      2: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
      default: begin
        if (n < 2)
          return table_times[0] + $urandom_range(0, 3) - 1;
        i  = $urandom_range(0, n - 2);
        lo = table_times[i];
        hi = table_times[i+1];
        if (hi > lo)
          return lo + $urandom_range(0, hi - lo - 1);
        return lo + $urandom_range(0, 15);
      end
    endcase
  endfunction

  // breakpoints mostly rising, with some repeats and rare drops
  task automatic append_points(input int unsigned n);
    logic [63:0] t_next;
    logic [63:0] room;
    int unsigned shift;
    t_next = $urandom >> $urandom_range(0, 31);
    room   = (64'hFFFF_FFFF - t_next) / n;
    shift  = $urandom_range(0, 24);
    for (int unsigned k = 0; k < n; k++) begin
      send_beat(OP_APPEND, t_next[31:0], pick_value());
      case ($urandom_range(0, 19))
        0:       ;
        1:       t_next = t_next >> 1;
        default: t_next = t_next + 1 + $urandom_range(0, 32'(room >> shift));
      endcase
    end
  endtask

  initial begin
    int unsigned phase;
    int unsigned directed_beats;
    int unsigned n;
    int unsigned m;
    logic [31:0] en_word;
    phase = 0;

    repeat (8) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // directed: defaults, clamps, interpolation extremes, op aliases, disable, clear
    send_beat(OP_QUERY, 32'h1234_5678, 32'hDEAD_BEEF);
    write_reg(CFG_DEFAULT_VALUE, 32'h8000_0000);
    send_beat(OP_QUERY, 32'h0000_0000, 32'h0);
    write_reg(CFG_DEFAULT_VALUE, 32'h7FFF_FFFF);
    send_beat(OP_QUERY_ALT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_beat(OP_APPEND, 32'h0001_0000, 32'h8000_0000);
    send_beat(OP_APPEND, 32'h0003_0000, 32'h7FFF_FFFF);
    send_beat(OP_QUERY, 32'h0000_0000, 32'h0);
    send_beat(OP_QUERY, 32'h0001_0000, 32'h0);
    send_beat(OP_QUERY, 32'h0002_FFFF, 32'h0);
    send_beat(OP_QUERY, 32'h0003_0000, 32'h0);
    send_beat(OP_APPEND, 32'h0003_0000, 32'h0000_0005);
    send_beat(OP_APPEND, 32'h0002_0000, 32'hFFFF_FFF9);
    send_beat(OP_QUERY, 32'h0001_8000, 32'h0);
    send_beat(OP_QUERY, 32'h0002_0000, 32'h0);
    send_beat(OP_QUERY_ALT, 32'h0001_0001, 32'h0);
    write_reg(CFG_TABLE_ENABLED, 32'hFFFF_FFFE);
    send_beat(OP_QUERY, 32'h0001_8000, 32'h0);
    write_reg(CFG_TABLE_ENABLED, 32'h0000_0001);
    send_beat(OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_beat(OP_QUERY, 32'h0001_8000, 32'h0);
    send_beat(OP_APPEND, 32'h0000_0000, 32'h7FFF_FFFF);
    send_beat(OP_APPEND, 32'hFFFF_FFFF, 32'h8000_0000);
    send_beat(OP_QUERY, 32'h8000_0000, 32'h0);
    send_beat(OP_QUERY, 32'hFFFF_FFFE, 32'h0);
    send_beat(OP_QUERY, 32'hFFFF_FFFF, 32'h0);
    send_beat(OP_CLEAR, 32'h0, 32'h0);
    write_reg(CFG_DEFAULT_VALUE, 32'h0000_0000);
    directed_beats = beats_sent;

    while (beats_sent < directed_beats + RANDOM_BEATS) begin
      phase++;
      idle_on = ($urandom_range(0, 3) != 0);
      if (phase == 6)
        idle_on = 1'b0;
      if ($urandom_range(0, 2) == 0) begin
        en_word    = $urandom;
        en_word[0] = ($urandom_range(0, 4) != 0);
        write_reg(CFG_TABLE_ENABLED, en_word);
      end
      if ($urandom_range(0, 2) == 0)
        write_reg(CFG_DEFAULT_VALUE, pick_value());
      if (phase == 4) begin
        // fill the table past its capacity
        send_beat(OP_CLEAR, $urandom, $urandom);
        append_points(MAX_POINTS + 2);
      end else begin
        if ($urandom_range(0, 4) != 0)
          send_beat(OP_CLEAR, $urandom, $urandom);
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
        append_points(n);
      end
      if (phase == 6)
        hold_req = 1'b1;
      m = $urandom_range(3, 12);
      repeat (m) begin
        if ($urandom_range(0, 9) == 0)
          send_beat(2'($urandom_range(0, 3)), $urandom, $urandom);
        else
          send_beat({1'b1, 1'($urandom)}, pick_query_time(), $urandom);
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results == 0)
      $display("tb_breakpoint_linear_interpolator_top: PASS");
    else
      $display("tb_breakpoint_linear_interpolator_top: FAIL");
    $finish;
  end

endmodule

FILE: files.f
src/bli_pkg.sv
src/bli_ctrl.sv
src/bli_dp.sv
src/breakpoint_linear_interpolator_top.sv
test/bli_result_checker.sv
test/tb_breakpoint_linear_interpolator_top.sv
